>>> sv/krcs_pkg.sv
// Shared types and constants for the Korean charset detector.
package krcs_pkg;

    localparam int MAX_RUN_BYTES = 4096;
    localparam int CNT_W         = 13;
    localparam int SCORE_W       = 14;

    localparam logic [CNT_W-1:0] RUN_LIMIT      = CNT_W'(MAX_RUN_BYTES);
    localparam logic [CNT_W-1:0] RUN_LAST_INDEX = CNT_W'(MAX_RUN_BYTES - 1);

    typedef enum logic [2:0] {
        ENC_UNKNOWN = 3'd0,
        ENC_ASCII   = 3'd1,
        ENC_UTF8    = 3'd2,
        ENC_CP949   = 3'd3,
        ENC_JOHAB   = 3'd4,
        ENC_CP437   = 3'd5
    } enc_code_t;

    // Per-byte control shared by all scorers
    typedef struct packed {
        logic step;        // byte is inside the run limit and gets scored
        logic clear;       // run ends with this transaction
        logic final_byte;  // last scored byte: no lookahead after it
    } feed_ctrl_t;

    typedef struct packed {
        logic             failed;
        logic [CNT_W-1:0] total;
    } utf8_stat_t;

endpackage

>>> sv/krcs_utf8.sv
// UTF-8 well-formedness scorer.
module krcs_utf8 (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  krcs_pkg::feed_ctrl_t ctrl,
    input  logic [7:0]           data_byte,
    output krcs_pkg::utf8_stat_t score_next
);
    import krcs_pkg::*;

    logic [CNT_W-1:0] total_reg,     total_next;
    logic             failed_reg,    failed_next;
    logic [1:0]       remaining_reg, remaining_next;
    logic [1:0]       seq_len_reg,   seq_len_next;
    logic             seq_bad_reg,   seq_bad_next;
    logic             cont_bad;

    always_comb begin
        total_next     = total_reg;
        failed_next    = failed_reg;
        remaining_next = remaining_reg;
        seq_len_next   = seq_len_reg;
        seq_bad_next   = seq_bad_reg;
        cont_bad       = seq_bad_reg | (data_byte[7:6] != 2'b10);
        if (ctrl.step && !failed_reg) begin
            if (remaining_reg != 2'd0) begin
                remaining_next = remaining_reg - 2'd1;
                seq_bad_next   = cont_bad;
                if (remaining_reg == 2'd1) begin
                    // close the sequence
                    if (cont_bad) begin
                        failed_next = 1'b1;
                    end else begin
                        total_next = total_reg + CNT_W'(seq_len_reg) + CNT_W'(1);
                    end
                    seq_bad_next = 1'b0;
                    seq_len_next = 2'd0;
                end
            end else if (data_byte[7]) begin
                priority if (data_byte[7:5] == 3'b110) begin
                    seq_len_next   = 2'd1;
                    remaining_next = 2'd1;
                    seq_bad_next   = 1'b0;
                end else if (data_byte[7:4] == 4'b1110) begin
                    seq_len_next   = 2'd2;
                    remaining_next = 2'd2;
                    seq_bad_next   = 1'b0;
                end else if (data_byte[7:3] == 5'b11110) begin
                    seq_len_next   = 2'd3;
                    remaining_next = 2'd3;
                    seq_bad_next   = 1'b0;
                end else begin
                    failed_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            total_reg     <= '0;
            failed_reg    <= 1'b0;
            remaining_reg <= 2'd0;
            seq_len_reg   <= 2'd0;
            seq_bad_reg   <= 1'b0;
        end else begin
            total_reg     <= total_next;
            failed_reg    <= failed_next;
            remaining_reg <= remaining_next;
            seq_len_reg   <= seq_len_next;
            seq_bad_reg   <= seq_bad_next;
        end
    end

    assign score_next.failed = failed_next;
    assign score_next.total  = total_next;

endmodule

>>> sv/krcs_pair.sv
// Double-byte pair scorer for CP949 or JOHAB lead/trail ranges.
module krcs_pair (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               johab_mode,
    input  krcs_pkg::feed_ctrl_t               ctrl,
    input  logic [7:0]                         data_byte,
    output logic signed [krcs_pkg::SCORE_W-1:0] score_next
);
    import krcs_pkg::*;

    logic signed [SCORE_W-1:0] score_reg;
    logic                      pending_reg, pending_next;
    logic signed [2:0]         delta;
    logic                      trail_hit;
    logic                      lead_ok;
    logic                      cp949_trail;
    logic                      johab_trail;

    always_comb begin
        cp949_trail = (data_byte >= 8'h41 && data_byte <= 8'h5A) ||
                      (data_byte >= 8'h61 && data_byte <= 8'h7A) ||
                      (data_byte >= 8'h81 && data_byte <= 8'hFE);
        johab_trail = (data_byte >= 8'h41 && data_byte <= 8'h7E) ||
                      (data_byte >= 8'h81 && data_byte <= 8'hFE);
        trail_hit   = johab_mode ? johab_trail : cp949_trail;
        lead_ok     = johab_mode ? (data_byte >= 8'h84 && data_byte <= 8'hD3)
                                 : (data_byte >= 8'h81 && data_byte <= 8'hFE);
    end

    always_comb begin
        delta        = 3'sd0;
        pending_next = pending_reg;
        if (ctrl.step) begin
            pending_next = 1'b0;
            if (pending_reg && trail_hit) begin
                delta = 3'sd2;
            end else begin
                // a failed trail is retried as a lead
                if (pending_reg) begin
                    delta = -3'sd1;
                end
                if (!ctrl.final_byte && data_byte[7]) begin
                    if (lead_ok) begin
                        pending_next = 1'b1;
                    end else begin
                        delta = delta - 3'sd1;
                    end
                end
            end
        end
        score_next = score_reg + {{(SCORE_W-3){delta[2]}}, delta};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            score_reg   <= '0;
            pending_reg <= 1'b0;
        end else begin
            score_reg   <= score_next;
            pending_reg <= pending_next;
        end
    end

endmodule

>>> sv/krcs_decide.sv
// Encoding decision from the final scores of a run.
module krcs_decide (
    input  krcs_pkg::utf8_stat_t                utf8_stat,
    input  logic signed [krcs_pkg::SCORE_W-1:0] cp949_sum,
    input  logic signed [krcs_pkg::SCORE_W-1:0] johab_sum,
    input  logic [krcs_pkg::CNT_W-1:0]          high_count,
    output krcs_pkg::enc_code_t                 encoding_code
);
    import krcs_pkg::*;

    logic signed [SCORE_W-1:0] half;
    logic                      cp_wins;
    logic                      jo_wins;

    always_comb begin
        half    = {{(SCORE_W-CNT_W+1){1'b0}}, high_count[CNT_W-1:1]};
        cp_wins = (cp949_sum > 0) && (cp949_sum > half) && (cp949_sum >= johab_sum);
        jo_wins = (johab_sum > 0) && (johab_sum > half) && (johab_sum > cp949_sum);
        priority if (!utf8_stat.failed && high_count == '0) begin
            encoding_code = ENC_ASCII;
        end else if (!utf8_stat.failed && utf8_stat.total != '0) begin
            encoding_code = ENC_UTF8;
        end else if (cp_wins) begin
            encoding_code = ENC_CP949;
        end else if (jo_wins) begin
            encoding_code = ENC_JOHAB;
        end else begin
            encoding_code = ENC_CP437;
        end
    end

endmodule

>>> sv/korean_charset_detector.sv
// Top level of the Korean charset detector: byte stream in, one verdict per run out.
//
// Feed a run one byte per transaction on the s_ side; tlast marks the run's last byte.
// The block takes one byte every clock while s_tready is high. The UTF-8, CP949 and
// JOHAB scorers and the high-byte counter all update in the same cycle the byte is
// accepted; a run's verdict goes into a single output register as its last byte is
// accepted. s_tready drops only while that register holds an untaken verdict.
// Only the first 4096 bytes of a run are scored; later bytes set the overflow flag.
module korean_charset_detector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [2:0] encoding_code, [16:3] utf8_result,
                                   // [30:17] cp949_result, [44:31] johab_result,
                                   // [57:45] high_byte_total, [63:58] zero
    output logic        m_tuser    // overflow_flag
);
    import krcs_pkg::*;

    logic                      s_accept;
    logic                      in_range;
    feed_ctrl_t                ctrl;
    logic [CNT_W-1:0]          byte_count_reg, byte_count_next;
    logic [CNT_W-1:0]          high_count_reg, high_count_next;
    logic                      overflow_reg,   overflow_next;
    utf8_stat_t                utf8_stat;
    logic signed [SCORE_W-1:0] cp949_sum;
    logic signed [SCORE_W-1:0] johab_sum;
    logic signed [SCORE_W-1:0] utf8_result;
    enc_code_t                 encoding_code;
    logic                      m_valid_reg;
    logic [63:0]               m_tdata_reg, m_tdata_next;
    logic                      m_tuser_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign in_range = byte_count_reg < RUN_LIMIT;

    always_comb begin
        ctrl.step       = s_accept && in_range;
        ctrl.clear      = s_accept && s_tlast;
        ctrl.final_byte = s_tlast || (byte_count_reg == RUN_LAST_INDEX);
        byte_count_next = byte_count_reg + CNT_W'(ctrl.step);
        high_count_next = high_count_reg + CNT_W'(ctrl.step && s_tdata[7]);
        overflow_next   = overflow_reg | (s_accept && !in_range);
    end

    krcs_utf8 u_utf8 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .data_byte  (s_tdata),
        .score_next (utf8_stat)
    );

    krcs_pair u_cp949 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .johab_mode (1'b0),
        .ctrl       (ctrl),
        .data_byte  (s_tdata),
        .score_next (cp949_sum)
    );

    krcs_pair u_johab (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .johab_mode (1'b1),
        .ctrl       (ctrl),
        .data_byte  (s_tdata),
        .score_next (johab_sum)
    );

    krcs_decide u_decide (
        .utf8_stat     (utf8_stat),
        .cp949_sum     (cp949_sum),
        .johab_sum     (johab_sum),
        .high_count    (high_count_next),
        .encoding_code (encoding_code)
    );

    always_comb begin
        utf8_result  = utf8_stat.failed ? -SCORE_W'(1)
                                        : {{(SCORE_W-CNT_W){1'b0}}, utf8_stat.total};
        m_tdata_next = {6'd0, high_count_next, johab_sum, cp949_sum,
                        utf8_result, encoding_code};
    end

    // run counters: restart after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            byte_count_reg <= '0;
            high_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            high_count_reg <= high_count_next;
            overflow_reg   <= overflow_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= overflow_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
